/* sv/pndp_pkg.sv */
package pndp_pkg;

  // Field widths
  localparam int DEPTH_W = 24;
  localparam int KEY_W   = 24;
  localparam int BYTE_W  = 8;
  localparam int INST_W  = 32;
  localparam int COORD_W = 10;
  localparam int RES_W   = 11;

  // Full-scale depth marks background
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = '1;

  // Defaults for the top-level parameters and the resolution register
  localparam int DEF_TABLE_ENTRIES = 32;
  localparam int DEF_MAX_SIDE      = 1024;
  localparam logic [RES_W-1:0] RES_RESET = RES_W'(128);

  // Smallest power of two at least res; zero and one both give one
  function automatic logic [RES_W:0] pow2_ceil(input logic [RES_W-1:0] res);
    logic [RES_W:0] p;
    p = (RES_W+1)'(1);
    for (int b = 0; b < RES_W; b++) begin
      if (res > (RES_W'(1) << b)) begin
        p = (RES_W+1)'(1) << (b + 1);
      end
    end
    return p;
  endfunction

endpackage

/* sv/pndp_key_cam.sv */
module pndp_key_cam #(
  parameter int ENTRIES = pndp_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] waddr_i,
  input  logic [pndp_pkg::KEY_W-1:0] wkey_i,
  input  logic [$clog2(ENTRIES + 1)-1:0] fill_i,
  input  logic [pndp_pkg::KEY_W-1:0] key_i,
  output logic                       hit_o,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] idx_o,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] raddr_i,
  output logic [pndp_pkg::KEY_W-1:0] rkey_o
);
  import pndp_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NW = $clog2(ENTRIES + 1);

  logic [KEY_W-1:0] key_q [ENTRIES];

  // Key store, one slot written per new id
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_q[waddr_i] <= wkey_i;
    end
  end

  // Parallel compare over the filled slots; ids are unique so at most one hits
  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if ((NW'(i) < fill_i) && (key_q[i] == key_i)) begin
        hit_o = 1'b1;
        idx_o = idx_o | IW'(i);
      end
    end
  end

  // Readout port
  assign rkey_o = key_q[raddr_i];

endmodule

/* sv/per_id_nearest_depth_pick.sv */
// Nearest-depth pick per object id. Pixels of a square frame arrive in raster
// order; the frame side is pick_resolution rounded up to a power of two and
// limited to MAX_SIDE. Each pixel, background or not, gets a key compare
// against the id store on transfer, a read of the entry memory, then the
// compare-and-write-back of that entry; this read-modify-write ends before the
// next pixel is taken. On the last pixel of the frame the table is streamed
// out in order of first appearance (or one no-hit result), each result read
// and then loaded when the output is not stalled; the table is then reset by
// clearing its fill count; there is no clearing pass after reset or per frame.
// A finished result waits in an output register while new pixels are taken.
module per_id_nearest_depth_pick #(
  parameter int TABLE_ENTRIES = pndp_pkg::DEF_TABLE_ENTRIES,
  parameter int MAX_SIDE      = pndp_pkg::DEF_MAX_SIDE
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         pick_resolution_we_i,
  input  logic [pndp_pkg::RES_W-1:0]   pick_resolution_i,
  // pixel input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pndp_pkg::DEPTH_W-1:0] pixel_depth_i,
  input  logic [pndp_pkg::BYTE_W-1:0]  id_red_i,
  input  logic [pndp_pkg::BYTE_W-1:0]  id_green_i,
  input  logic [pndp_pkg::BYTE_W-1:0]  id_blue_i,
  input  logic [pndp_pkg::BYTE_W-1:0]  id_alpha_i,
  input  logic [pndp_pkg::INST_W-1:0]  instance_word_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         any_hit_o,
  output logic [pndp_pkg::KEY_W-1:0]   hit_object_id_o,
  output logic [pndp_pkg::BYTE_W-1:0]  hit_alpha_o,
  output logic [pndp_pkg::INST_W-1:0]  hit_instance_word_o,
  output logic [pndp_pkg::COORD_W-1:0] hit_x_o,
  output logic [pndp_pkg::COORD_W-1:0] hit_y_o,
  output logic [pndp_pkg::DEPTH_W-1:0] hit_depth_o,
  output logic                         last_result_o,
  output logic                         table_overflow_o
);
  import pndp_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NW = $clog2(TABLE_ENTRIES + 1);
  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = CW + 1;
  localparam logic [NW-1:0] FULL_COUNT = NW'(TABLE_ENTRIES);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DLD  = 3'd4;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [CW-1:0]      x;
    logic [CW-1:0]      y;
    logic [BYTE_W-1:0]  alpha;
    logic [INST_W-1:0]  inst;
  } entry_t;

  function automatic logic [SW-1:0] side_of(input logic [RES_W-1:0] res);
    logic [RES_W:0] p;
    p = pow2_ceil(res);
    if (p > (RES_W+1)'(MAX_SIDE)) begin
      return SW'(MAX_SIDE);
    end
    return SW'(p);
  endfunction

  localparam logic [SW-1:0] SIDE_RESET = side_of(RES_RESET);

  logic [2:0]         state_q, state_d;
  logic [SW-1:0]      side_q;
  logic [NW-1:0]      count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [CW-1:0]      sx_q, sx_d, sy_q, sy_d;
  logic [IW-1:0]      ptr_q, ptr_d;
  logic               out_valid_q, out_valid_d;

  logic [DEPTH_W-1:0] px_depth_q;
  logic [KEY_W-1:0]   px_key_q;
  logic [BYTE_W-1:0]  px_alpha_q;
  logic [INST_W-1:0]  px_inst_q;
  logic               hit_q;
  logic [IW-1:0]      idx_q;

  entry_t             mem_q [TABLE_ENTRIES];
  entry_t             rd_q;
  entry_t             wr_data;
  logic [IW-1:0]      rd_addr, wr_addr;
  logic               wr_en;

  logic [KEY_W-1:0]   in_key;
  logic               cam_hit;
  logic [IW-1:0]      cam_idx;
  logic [KEY_W-1:0]   cam_rkey;

  logic               in_xfer, bg, room, upd_wr, new_wr, drop;
  logic               row_end, frame_end, load_en, out_last, empty;

  logic               any_hit_q, last_q, ovf_out_q;
  logic [KEY_W-1:0]   key_out_q;
  entry_t             ent_out_q;

  assign in_key   = {id_blue_i, id_green_i, id_red_i};
  assign in_xfer  = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  pndp_key_cam #(
    .ENTRIES(TABLE_ENTRIES)
  ) u_cam (
    .clk_i  (clk_i),
    .we_i   (wr_en && new_wr),
    .waddr_i(count_q[IW-1:0]),
    .wkey_i (px_key_q),
    .fill_i (count_q),
    .key_i  (in_key),
    .hit_o  (cam_hit),
    .idx_o  (cam_idx),
    .raddr_i(ptr_q),
    .rkey_o (cam_rkey)
  );

  // Entry update decision
  assign bg     = (px_depth_q == DEPTH_FULL);
  assign room   = (count_q < FULL_COUNT);
  assign upd_wr = !bg && hit_q && (px_depth_q < rd_q.depth);
  assign new_wr = !bg && !hit_q && room;
  assign drop   = !bg && !hit_q && !room;
  assign wr_en  = (state_q == S_UPD) && (upd_wr || new_wr);
  assign wr_addr = hit_q ? idx_q : count_q[IW-1:0];
  assign rd_addr = (state_q == S_READ) ? idx_q : ptr_q;

  always_comb begin
    wr_data.depth = px_depth_q;
    wr_data.x     = sx_q;
    wr_data.y     = sy_q;
    wr_data.alpha = px_alpha_q;
    wr_data.inst  = px_inst_q;
  end

  // Scan position bounds
  assign row_end   = ((SW'(sx_q) + SW'(1)) >= side_q);
  assign frame_end = row_end && ((SW'(sy_q) + SW'(1)) >= side_q);

  // Readout
  assign empty    = (count_q == '0);
  assign out_last = empty || ((NW'(ptr_q) + NW'(1)) == count_q);
  assign load_en  = (state_q == S_DLD) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (new_wr) begin
          count_d = count_q + NW'(1);
        end
        if (drop) begin
          ovf_d = 1'b1;
        end
        if (frame_end) begin
          sx_d    = '0;
          sy_d    = '0;
          ptr_d   = '0;
          state_d = S_DRD;
        end else begin
          state_d = S_IDLE;
          if (row_end) begin
            sx_d = '0;
            sy_d = sy_q + CW'(1);
          end else begin
            sx_d = sx_q + CW'(1);
          end
        end
      end
      S_DRD: begin
        state_d = S_DLD;
      end
      S_DLD: begin
        if (load_en) begin
          out_valid_d = 1'b1;
          if (out_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            ptr_d   = '0;
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q + IW'(1);
            state_d = S_DRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      side_q      <= SIDE_RESET;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      sx_q        <= '0;
      sy_q        <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (pick_resolution_we_i) begin
        side_q <= side_of(pick_resolution_i);
      end
    end
  end

  // Pixel capture and match result on input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_depth_q <= pixel_depth_i;
      px_key_q   <= in_key;
      px_alpha_q <= id_alpha_i;
      px_inst_q  <= instance_word_i;
      hit_q      <= cam_hit;
      idx_q      <= cam_idx;
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      any_hit_q <= !empty;
      last_q    <= out_last;
      ovf_out_q <= ovf_q;
      key_out_q <= empty ? '0 : cam_rkey;
      ent_out_q <= empty ? '0 : rd_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign any_hit_o           = any_hit_q;
  assign hit_object_id_o     = key_out_q;
  assign hit_alpha_o         = ent_out_q.alpha;
  assign hit_instance_word_o = ent_out_q.inst;
  assign hit_x_o             = COORD_W'(ent_out_q.x);
  assign hit_y_o             = COORD_W'(ent_out_q.y);
  assign hit_depth_o         = ent_out_q.depth;
  assign last_result_o       = last_q;
  assign table_overflow_o    = ovf_out_q;

endmodule

/* sv/pndp_checker.sv */
module pndp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         any_hit_o,
  input logic [pndp_pkg::KEY_W-1:0]   hit_object_id_o,
  input logic [pndp_pkg::DEPTH_W-1:0] hit_depth_o,
  input logic                         last_result_o
);
  import pndp_pkg::*;

  // The input stalls after every pixel transfer; pixels are never taken back to back
  a_busy_after_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("pixel taken back to back");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_object_id_o)
      && $stable(hit_depth_o) && $stable(last_result_o))
    else $error("stalled result changed");

  // The no-hit result closes the readout and carries zeros
  a_nohit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !any_hit_o |-> last_result_o && (hit_object_id_o == '0)
      && (hit_depth_o == '0))
    else $error("malformed no-hit result");

  // Background depth never reaches the table
  a_no_bg_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && any_hit_o |-> hit_depth_o != DEPTH_FULL)
    else $error("background depth reported as hit");

endmodule

bind per_id_nearest_depth_pick pndp_checker u_pndp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .any_hit_o      (any_hit_o),
  .hit_object_id_o(hit_object_id_o),
  .hit_depth_o    (hit_depth_o),
  .last_result_o  (last_result_o)
);
